// File: design/spi_nor_flash_command_sequencer_core_defines.svh
// Assertion macros for the SPI NOR command sequencer.
// Used by the top level only; no other dependencies.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH
// check a property on the rising clock, quiet while reset is held
`define SNF_ASSERT(label, prop, msg) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// check a property on the rising clock, also during reset
`define SNF_ASSERT_ALWAYS(label, prop, msg) \
label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

// File: design/snf_pkg.sv
// Shared types and codes of the SPI NOR command sequencer.
// No dependencies.
package snf_pkg;
    localparam logic [2:0] OP_RDID = 3'd0, OP_READ = 3'd1, OP_WSTART = 3'd2,
        OP_WBYTE = 3'd3, OP_SERASE = 3'd4, OP_CERASE = 3'd5, OP_REPLY = 3'd6;
    localparam logic [2:0] K_SPI = 3'd0, K_DESEL = 3'd1, K_RDATA = 3'd2,
        K_ID = 3'd3, K_DONE = 3'd4, K_ERR = 3'd5;
    localparam logic [7:0] CMD_WREN = 8'h06, CMD_RDSR = 8'h05, CMD_READ = 8'h03,
        CMD_PP = 8'h02, CMD_SE = 8'h20, CMD_CE = 8'hC7, CMD_RDID = 8'h9F,
        BUSY_MASK = 8'h01, DUMMY = 8'hFF;

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  spi_byte;
        logic        end_select;
        logic        expect_reply;
        logic [23:0] value;
        logic        last;
    } t_res;

    // one input item
    typedef struct packed {
        logic [2:0]  op;
        logic [23:0] address;
        logic [24:0] byte_count;
        logic [7:0]  data_byte;
    } t_item;

    function automatic t_res mk(input logic [2:0] k, input logic [7:0] b,
                                input logic e, input logic x, input logic [23:0] v);
        t_res r;
        r.kind = k; r.spi_byte = b; r.end_select = e; r.expect_reply = x;
        r.value = v; r.last = 1'b0;
        return r;
    endfunction
endpackage

// File: design/snf_front.sv
// Front part: accepts items, runs the phase state and builds a short list of results.
// Depends on snf_pkg.
module snf_front import snf_pkg::*; #(
    parameter int PAGE_BYTES   = 256,
    parameter int DEVICE_BYTES = 16777216
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res [7:0]  o_list,
    output logic [3:0]  o_count
);
    localparam int PW = $clog2(PAGE_BYTES) + 1;
    localparam logic [3:0] PH_IDLE = 4'd0, PH_ID = 4'd1, PH_READ = 4'd2,
        PH_WDATA = 4'd3, PH_BUSY_W = 4'd4, PH_BUSY_E = 4'd5;

    logic [3:0]  r_phase, n_phase;
    logic [23:0] r_addr, n_addr;
    logic [24:0] r_rem, n_rem;
    logic [PW-1:0] r_pgl, n_pgl;
    logic [23:0] r_id, n_id;
    logic [1:0]  r_idn, n_idn;
    logic        r_valid;
    t_res [7:0]  r_list, n_list;
    logic [3:0]  r_count, n_count;
    logic        take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_list  = r_list;
    assign o_count = r_count;

    always_comb begin
        logic [3:0]    k;
        logic [PW-1:0] pleft;
        logic [25:0]   wend;
        logic [PW-1:0] off;
        logic          newpage;
        n_phase = r_phase; n_addr = r_addr; n_rem = r_rem; n_pgl = r_pgl;
        n_id = r_id; n_idn = r_idn;
        for (int j = 0; j < 8; j++) n_list[j] = mk(K_SPI, 8'h0, 1'b0, 1'b0, 24'h0);
        k = 4'd0; newpage = 1'b0;
        off = '0; pleft = '0;
        wend = {2'b0, i_item.address} + {1'b0, i_item.byte_count};
        if (i_item.op <= OP_CERASE && i_item.op != OP_WBYTE && r_phase != PH_IDLE) begin
            n_list[0] = mk(K_ERR, 8'h0, 1'b0, 1'b0, 24'h0); k = 4'd1;
        end else if (i_item.op == OP_WBYTE && r_phase != PH_WDATA) begin
            n_list[0] = mk(K_ERR, 8'h0, 1'b0, 1'b0, 24'h0); k = 4'd1;
        end else begin
            unique case (i_item.op)
                OP_RDID: begin
                    n_list[0] = mk(K_SPI, CMD_RDID, 1'b0, 1'b0, 24'h0);
                    n_list[1] = mk(K_SPI, DUMMY, 1'b0, 1'b1, 24'h0);
                    n_list[2] = mk(K_SPI, DUMMY, 1'b0, 1'b1, 24'h0);
                    n_list[3] = mk(K_SPI, DUMMY, 1'b1, 1'b1, 24'h0);
                    k = 4'd4; n_id = 24'h0; n_idn = 2'd0; n_phase = PH_ID;
                end
                OP_READ: begin
                    n_addr = i_item.address; n_rem = i_item.byte_count;
                    n_list[0] = mk(K_SPI, CMD_READ, 1'b0, 1'b0, 24'h0);
                    n_list[1] = mk(K_SPI, i_item.address[23:16], 1'b0, 1'b0, 24'h0);
                    n_list[2] = mk(K_SPI, i_item.address[15:8], 1'b0, 1'b0, 24'h0);
                    if (i_item.byte_count == 25'd0) begin
                        n_list[3] = mk(K_SPI, i_item.address[7:0], 1'b1, 1'b0, 24'h0);
                        n_list[4] = mk(K_DONE, 8'h0, 1'b0, 1'b0, 24'h0);
                        k = 4'd5;
                    end else begin
                        n_list[3] = mk(K_SPI, i_item.address[7:0], 1'b0, 1'b0, 24'h0);
                        n_list[4] = mk(K_SPI, DUMMY, i_item.byte_count == 25'd1, 1'b1, 24'h0);
                        k = 4'd5; n_phase = PH_READ;
                    end
                end
                OP_WSTART: begin
                    if (wend > 26'(DEVICE_BYTES)) begin
                        n_list[0] = mk(K_ERR, 8'h0, 1'b0, 1'b0, 24'h0); k = 4'd1;
                    end else if (i_item.byte_count == 25'd0) begin
                        n_list[0] = mk(K_DONE, 8'h0, 1'b0, 1'b0, 24'h0); k = 4'd1;
                    end else begin
                        n_addr = i_item.address; n_rem = i_item.byte_count; newpage = 1'b1;
                    end
                end
                OP_WBYTE: begin
                    n_list[0] = mk(K_SPI, i_item.data_byte, r_pgl == PW'(1), 1'b0, 24'h0);
                    k = 4'd1;
                    if (r_pgl != '0) n_pgl = r_pgl - PW'(1);
                    if (r_rem != '0) n_rem = r_rem - 25'd1;
                    n_addr = r_addr + 24'd1;
                    if (n_pgl == '0) begin
                        n_list[1] = mk(K_SPI, CMD_RDSR, 1'b0, 1'b0, 24'h0);
                        n_list[2] = mk(K_SPI, DUMMY, 1'b0, 1'b1, 24'h0);
                        k = 4'd3; n_phase = PH_BUSY_W;
                    end
                end
                OP_SERASE: begin
                    n_list[0] = mk(K_SPI, CMD_WREN, 1'b1, 1'b0, 24'h0);
                    n_list[1] = mk(K_SPI, CMD_SE, 1'b0, 1'b0, 24'h0);
                    n_list[2] = mk(K_SPI, i_item.address[23:16], 1'b0, 1'b0, 24'h0);
                    n_list[3] = mk(K_SPI, i_item.address[15:8], 1'b0, 1'b0, 24'h0);
                    n_list[4] = mk(K_SPI, i_item.address[7:0], 1'b1, 1'b0, 24'h0);
                    n_list[5] = mk(K_SPI, CMD_RDSR, 1'b0, 1'b0, 24'h0);
                    n_list[6] = mk(K_SPI, DUMMY, 1'b0, 1'b1, 24'h0);
                    k = 4'd7; n_phase = PH_BUSY_E;
                end
                OP_CERASE: begin
                    n_list[0] = mk(K_SPI, CMD_WREN, 1'b1, 1'b0, 24'h0);
                    n_list[1] = mk(K_SPI, CMD_CE, 1'b1, 1'b0, 24'h0);
                    n_list[2] = mk(K_SPI, CMD_RDSR, 1'b0, 1'b0, 24'h0);
                    n_list[3] = mk(K_SPI, DUMMY, 1'b0, 1'b1, 24'h0);
                    k = 4'd4; n_phase = PH_BUSY_E;
                end
                OP_REPLY: begin
                    if (r_phase == PH_ID) begin
                        n_id = {r_id[15:0], i_item.data_byte};
                        n_idn = r_idn + 2'd1;
                        if (r_idn == 2'd2) begin
                            n_list[0] = mk(K_ID, 8'h0, 1'b0, 1'b0, n_id);
                            n_list[1] = mk(K_DONE, 8'h0, 1'b0, 1'b0, 24'h0);
                            k = 4'd2; n_phase = PH_IDLE;
                        end
                    end else if (r_phase == PH_READ) begin
                        n_list[0] = mk(K_RDATA, 8'h0, 1'b0, 1'b0, {16'h0, i_item.data_byte});
                        if (r_rem != '0) n_rem = r_rem - 25'd1;
                        n_addr = r_addr + 24'd1;
                        if (n_rem != '0) begin
                            n_list[1] = mk(K_SPI, DUMMY, n_rem == 25'd1, 1'b1, 24'h0);
                        end else begin
                            n_list[1] = mk(K_DONE, 8'h0, 1'b0, 1'b0, 24'h0);
                            n_phase = PH_IDLE;
                        end
                        k = 4'd2;
                    end else if (r_phase == PH_BUSY_W || r_phase == PH_BUSY_E) begin
                        if ((i_item.data_byte & BUSY_MASK) != 8'h0) begin
                            n_list[0] = mk(K_SPI, DUMMY, 1'b0, 1'b1, 24'h0); k = 4'd1;
                        end else begin
                            n_list[0] = mk(K_DESEL, 8'h0, 1'b0, 1'b0, 24'h0); k = 4'd1;
                            if (r_phase == PH_BUSY_W && r_rem != '0) begin
                                newpage = 1'b1;
                            end else begin
                                n_list[1] = mk(K_DONE, 8'h0, 1'b0, 1'b0, 24'h0);
                                k = 4'd2; n_phase = PH_IDLE;
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (newpage) begin
                // each page runs to the page boundary, clipped by what is left
                off = {1'b0, n_addr[PW-2:0]};
                pleft = PW'(PAGE_BYTES) - off;
                if ({{(25-PW){1'b0}}, pleft} > n_rem) pleft = n_rem[PW-1:0];
                n_pgl = pleft;
                n_list[k[2:0]]       = mk(K_SPI, CMD_WREN, 1'b1, 1'b0, 24'h0);
                n_list[3'(k + 4'd1)] = mk(K_SPI, CMD_PP, 1'b0, 1'b0, 24'h0);
                n_list[3'(k + 4'd2)] = mk(K_SPI, n_addr[23:16], 1'b0, 1'b0, 24'h0);
                n_list[3'(k + 4'd3)] = mk(K_SPI, n_addr[15:8], 1'b0, 1'b0, 24'h0);
                n_list[3'(k + 4'd4)] = mk(K_SPI, n_addr[7:0], 1'b0, 1'b0, 24'h0);
                k = k + 4'd5; n_phase = PH_WDATA;
            end
        end
        n_count = k;
        if (k != 4'd0) n_list[3'(k - 4'd1)].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_addr <= '0; r_rem <= '0; r_pgl <= '0;
            r_id <= '0; r_idn <= '0; r_valid <= 1'b0; r_count <= '0;
        end else begin
            if (o_ready) r_valid <= take && n_count != 4'd0;
            if (take) begin
                r_phase <= n_phase; r_addr <= n_addr; r_rem <= n_rem; r_pgl <= n_pgl;
                r_id <= n_id; r_idn <= n_idn; r_count <= n_count;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (take) r_list <= n_list;
    end
endmodule

// File: design/snf_back.sv
// Back part: a two-entry queue of result lists, unloaded one result per cycle while the receiver is ready.
// Depends on snf_pkg.
module snf_back import snf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_res [7:0]  i_list,
    input  logic [3:0]  i_count,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res        o_res
);
    t_res [1:0][7:0] r_q;
    logic [1:0][3:0] r_n;
    logic            r_wp, r_rp;
    logic [1:0]      r_fill;
    logic [2:0]      r_idx;
    logic            push, pop, fin;

    assign o_ready = r_fill != 2'd2;
    assign push    = i_valid && o_ready;
    assign o_valid = r_fill != 2'd0;
    assign o_res   = r_q[r_rp][r_idx];
    assign pop     = o_valid && i_ready;
    assign fin     = pop && ({1'b0, r_idx} == r_n[r_rp] - 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_fill <= '0; r_idx <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (fin) begin
                r_rp <= !r_rp; r_idx <= '0;
            end else if (pop) begin
                r_idx <= r_idx + 3'd1;
            end
            r_fill <= r_fill + {1'b0, push} - {1'b0, fin};
        end
    end
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_list; r_n[r_wp] <= i_count;
        end
    end
endmodule

// File: design/spi_nor_flash_command_sequencer_core.sv
// Top level of the SPI NOR flash command sequencer.
// Depends on snf_pkg, snf_front, snf_back and the defines header.
//
// channel | dir | tdata fields (low bit first)                                  | tuser
// s_axis  | in  | address[23:0] byte_count[48:24] data[56:49]                   | op[2:0]
// m_axis  | out | spi_byte[7:0] end_select[8] expect_reply[9] value[33:10]      | kind[2:0]
//
// Rate: the front takes one item per cycle while s_axis_tready is high; each
// item yields zero to seven results, which the back sends one per cycle while
// m_axis_tready is high. Results pass the front's list register, then the back's queue.
// Reset is synchronous, active low, and clears all control state.
// Stalls on m_axis fill the two-list queue and then hold s_axis_tready low.
`include "spi_nor_flash_command_sequencer_core_defines.svh"
module spi_nor_flash_command_sequencer_core import snf_pkg::*; #(
    parameter int PAGE_BYTES   = 256,
    parameter int DEVICE_BYTES = 16777216
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // address, byte_count, data_byte
    input  logic [2:0]  s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // spi_byte, end_select, expect_reply, value
    output logic [2:0]  m_axis_tuser,  // kind
    output logic        m_axis_tlast
);
    t_item      item;
    t_res [7:0] list;
    logic [3:0] cnt;
    logic       lst_valid, lst_ready;
    t_res       res;

    assign item.op         = s_axis_tuser;
    assign item.address    = s_axis_tdata[23:0];
    assign item.byte_count = s_axis_tdata[48:24];
    assign item.data_byte  = s_axis_tdata[56:49];

    snf_front #(.PAGE_BYTES(PAGE_BYTES), .DEVICE_BYTES(DEVICE_BYTES)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(item),
        .o_valid(lst_valid), .i_ready(lst_ready), .o_list(list), .o_count(cnt)
    );

    snf_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(lst_valid), .o_ready(lst_ready), .i_list(list), .i_count(cnt),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {6'b0, res.value, res.expect_reply, res.end_select,
                           res.spi_byte};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

    `SNF_ASSERT(a_no_empty_list, lst_valid |-> cnt != 4'd0, "empty result list queued")
    `SNF_ASSERT(a_kind_range, m_axis_tvalid |-> m_axis_tuser <= K_ERR, "bad result kind")
    `SNF_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
endmodule

// File: tb/sv/spi_nor_flash_command_sequencer_core_test.sv
// Self-checking bench for the SPI NOR flash command sequencer core.
// Depends on snf_pkg and spi_nor_flash_command_sequencer_core; a built-in
// predictor tracks the sequencer phase and checks every output item in order.
module spi_nor_flash_command_sequencer_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import snf_pkg::*;

    localparam int PAGE_SZ = 256;
    localparam int DEV_SZ  = 16777216;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic        B0  = 1'b0;
    localparam logic        B1  = 1'b1;
    localparam logic [7:0]  Z8  = 8'h00;
    localparam logic [23:0] Z24 = 24'h0;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ID, PH_READ, PH_WDATA, PH_BUSY_W, PH_BUSY_E
    } t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // address[23:0] byte_count[48:24] data[56:49]
    logic [2:0]  s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // spi_byte[7:0] end_sel[8] exp_reply[9] value[33:10]
    logic [2:0]  m_axis_tuser;   // kind
    logic        m_axis_tlast;

    spi_nor_flash_command_sequencer_core uut (.*);

    // predictor state
    t_phase      flash_phase = PH_IDLE;
    logic [23:0] cur_addr = '0;
    logic [24:0] bytes_left = '0;
    logic [12:0] pg_bytes = '0;
    logic [23:0] id_acc = '0;
    logic [1:0]  id_cnt = '0;

    t_res  expected_out[$];
    t_item pending_items[$];
    t_res  step_out[$];
    int    errors = 0;
    int    cycles = 0;
    bit    stim_done;
    int    hold_cycles = 0;
    int    burst_left;
    int    gap_left;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic void emit(logic [2:0] k, logic [7:0] b, logic e, logic x,
                                 logic [23:0] v);
        t_res r;
        r.kind = k; r.spi_byte = b; r.end_select = e; r.expect_reply = x;
        r.value = v; r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void begin_page();
        int room;
        room = PAGE_SZ - (cur_addr % PAGE_SZ);
        if (room > bytes_left) room = bytes_left;
        pg_bytes = 13'(room);
        emit(K_SPI, CMD_WREN, B1, B0, Z24);
        emit(K_SPI, CMD_PP, B0, B0, Z24);
        emit(K_SPI, cur_addr[23:16], B0, B0, Z24);
        emit(K_SPI, cur_addr[15:8], B0, B0, Z24);
        emit(K_SPI, cur_addr[7:0], B0, B0, Z24);
        flash_phase = PH_WDATA;
    endfunction

    function automatic void begin_poll();
        emit(K_SPI, CMD_RDSR, B0, B0, Z24);
        emit(K_SPI, DUMMY, B0, B1, Z24);
    endfunction

    // computes the output items caused by one accepted request
    function automatic void predict_sequencer(t_item it);
        step_out.delete();
        if (it.op <= OP_CERASE && it.op != OP_WBYTE && flash_phase != PH_IDLE) begin
            emit(K_ERR, Z8, B0, B0, Z24);
        end else if (it.op == OP_WBYTE && flash_phase != PH_WDATA) begin
            emit(K_ERR, Z8, B0, B0, Z24);
        end else begin
            case (it.op)
                OP_RDID: begin
                    emit(K_SPI, CMD_RDID, B0, B0, Z24);
                    emit(K_SPI, DUMMY, B0, B1, Z24);
                    emit(K_SPI, DUMMY, B0, B1, Z24);
                    emit(K_SPI, DUMMY, B1, B1, Z24);
                    id_acc = '0; id_cnt = '0; flash_phase = PH_ID;
                end
                OP_READ: begin
                    cur_addr = it.address; bytes_left = it.byte_count;
                    emit(K_SPI, CMD_READ, B0, B0, Z24);
                    emit(K_SPI, it.address[23:16], B0, B0, Z24);
                    emit(K_SPI, it.address[15:8], B0, B0, Z24);
                    if (it.byte_count == 25'd0) begin
                        emit(K_SPI, it.address[7:0], B1, B0, Z24);
                        emit(K_DONE, Z8, B0, B0, Z24);
                    end else begin
                        emit(K_SPI, it.address[7:0], B0, B0, Z24);
                        emit(K_SPI, DUMMY, it.byte_count == 25'd1, B1, Z24);
                        flash_phase = PH_READ;
                    end
                end
                OP_WSTART: begin
                    if (int'(it.address) + int'(it.byte_count) > DEV_SZ)
                        emit(K_ERR, Z8, B0, B0, Z24);
                    else if (it.byte_count == 25'd0)
                        emit(K_DONE, Z8, B0, B0, Z24);
                    else begin
                        cur_addr = it.address; bytes_left = it.byte_count;
                        begin_page();
                    end
                end
                OP_WBYTE: begin
                    emit(K_SPI, it.data_byte, pg_bytes == 13'd1, B0, Z24);
                    if (pg_bytes > 0) pg_bytes--;
                    if (bytes_left > 0) bytes_left--;
                    cur_addr++;
                    if (pg_bytes == 13'd0) begin
                        begin_poll();
                        flash_phase = PH_BUSY_W;
                    end
                end
                OP_SERASE: begin
                    emit(K_SPI, CMD_WREN, B1, B0, Z24);
                    emit(K_SPI, CMD_SE, B0, B0, Z24);
                    emit(K_SPI, it.address[23:16], B0, B0, Z24);
                    emit(K_SPI, it.address[15:8], B0, B0, Z24);
                    emit(K_SPI, it.address[7:0], B1, B0, Z24);
                    begin_poll();
                    flash_phase = PH_BUSY_E;
                end
                OP_CERASE: begin
                    emit(K_SPI, CMD_WREN, B1, B0, Z24);
                    emit(K_SPI, CMD_CE, B1, B0, Z24);
                    begin_poll();
                    flash_phase = PH_BUSY_E;
                end
                OP_REPLY: begin
                    if (flash_phase == PH_ID) begin
                        id_acc = {id_acc[15:0], it.data_byte};
                        id_cnt++;
                        if (id_cnt == 2'd3) begin
                            emit(K_ID, Z8, B0, B0, id_acc);
                            emit(K_DONE, Z8, B0, B0, Z24);
                            flash_phase = PH_IDLE;
                        end
                    end else if (flash_phase == PH_READ) begin
                        emit(K_RDATA, Z8, B0, B0, {16'd0, it.data_byte});
                        if (bytes_left > 0) bytes_left--;
                        cur_addr++;
                        if (bytes_left > 0) emit(K_SPI, DUMMY, bytes_left == 25'd1, B1, Z24);
                        else begin
                            emit(K_DONE, Z8, B0, B0, Z24);
                            flash_phase = PH_IDLE;
                        end
                    end else if (flash_phase == PH_BUSY_W || flash_phase == PH_BUSY_E) begin
                        if ((it.data_byte & BUSY_MASK) != 8'h0) emit(K_SPI, DUMMY, B0, B1, Z24);
                        else begin
                            emit(K_DESEL, Z8, B0, B0, Z24);
                            if (flash_phase == PH_BUSY_W && bytes_left > 0) begin_page();
                            else begin
                                emit(K_DONE, Z8, B0, B0, Z24);
                                flash_phase = PH_IDLE;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i]) expected_out.push_back(step_out[i]);
    endfunction

    function automatic t_item make_req(logic [2:0] op, logic [23:0] a, logic [24:0] n,
                                       logic [7:0] d);
        t_item it;
        it.op = op; it.address = a; it.byte_count = n; it.data_byte = d;
        return it;
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom);
    endfunction

    // noise fields on ops that ignore them so every bit toggles
    function automatic void push_req(logic [2:0] op, logic [23:0] a, logic [24:0] n,
                                     logic [7:0] d);
        pending_items.push_back(make_req(op, a, n, d));
    endfunction

    // busy replies: some with bit 0 set, then one clear
    function automatic void push_poll();
        int polls;
        polls = $urandom_range(0, 3);
        repeat (polls) push_req(OP_REPLY, 24'($urandom), 25'($urandom), rnd_byte() | 8'h01);
        push_req(OP_REPLY, 24'($urandom), 25'($urandom), rnd_byte() & 8'hFE);
    endfunction

    function automatic void push_write(logic [23:0] a, int n);
        int in_page;
        int k;
        push_req(OP_WSTART, a, 25'(n), rnd_byte());
        if (int'(a) + n > DEV_SZ || n == 0) return;
        in_page = PAGE_SZ - (a % PAGE_SZ);
        for (k = 0; k < n; k++) begin
            push_req(OP_WBYTE, 24'($urandom), 25'($urandom), rnd_byte());
            in_page--;
            if (in_page == 0 || k == n - 1) begin
                push_poll();
                in_page = PAGE_SZ;
            end
        end
    endfunction

    function automatic void push_read(logic [23:0] a, int n);
        push_req(OP_READ, a, 25'(n), rnd_byte());
        repeat (n) push_req(OP_REPLY, 24'($urandom), 25'($urandom), rnd_byte());
    endfunction

    // ---- driver: bursts with random gaps ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_sequencer(make_req(s_axis_tuser, s_axis_tdata[23:0],
                    s_axis_tdata[48:24], s_axis_tdata[56:49]));
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold current item
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                t_item it;
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= it.op;
                s_axis_tdata <= {7'd0, it.data_byte, it.byte_count, it.address};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else burst_left <= burst_left - 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---- monitor and receiver stall pattern ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            cycles <= 0;
        end else begin
            cycles <= cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                t_res got;
                got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8],
                       m_axis_tdata[9], m_axis_tdata[33:10], m_axis_tlast};
                if (expected_out.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, expected none, got kind=%0d",
                             $time, got.kind);
                end else begin
                    t_res want;
                    want = expected_out.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch exp kind=%0d spi=%h es=%b er=%b val=%h last=%b",
                                 $time, want.kind, want.spi_byte, want.end_select,
                                 want.expect_reply, want.value, want.last);
                        $display("%0t:          got kind=%0d spi=%h es=%b er=%b val=%h last=%b",
                                 $time, got.kind, got.spi_byte, got.end_select,
                                 got.expect_reply, got.value, got.last);
                    end
                end
            end
            // random stalls, one long hold-off window, and some windows with ready held high
            if (cycles >= 300 && hold_cycles < 400) begin
                hold_cycles <= hold_cycles + 1;
                m_axis_tready <= 1'b0;
            end else if ((cycles / 500) % 3 == 1) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        int sel;
        stim_done = 0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: errors in idle, stray reply, undefined op
        push_req(OP_WBYTE, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
        push_req(OP_REPLY, 24'h0, 25'h0, 8'h00);
        push_req(3'd7, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
        // read id, with an out-of-phase request inside
        push_req(OP_RDID, 24'h0, 25'h0, 8'h00);
        push_req(OP_READ, 24'h000100, 25'd1, 8'h00);
        push_req(OP_REPLY, 24'h0, 25'h0, 8'hEF);
        push_req(OP_REPLY, 24'h0, 25'h0, 8'h40);
        push_req(OP_REPLY, 24'h0, 25'h0, 8'h18);
        push_read(24'hFFFFFF, 0);            // empty read
        push_read(24'h123456, 2);
        push_write(24'hFFFFFF, 2);           // past device end
        push_req(OP_WSTART, 24'h0, 25'h1000000, 8'h00); // whole device is in range
        push_write(24'h000010, 0);           // empty write
        push_write(24'hFFFFFE, 2);           // last bytes of device
        push_write(24'h0000FE, 3);           // crosses a page
        push_req(OP_SERASE, 24'hABCDEF, 25'h0, 8'h00);
        push_poll();
        push_req(OP_CERASE, 24'h0, 25'h0, 8'h00);
        push_poll();

        // random sequences
        while (pending_items.size() < 345) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: begin
                    push_req(OP_RDID, 24'($urandom), 25'($urandom), rnd_byte());
                    repeat (3) push_req(OP_REPLY, 24'($urandom), 25'($urandom), rnd_byte());
                end
                1, 2: push_read(24'($urandom), $urandom_range(0, 6));
                3, 4, 5: push_write(($urandom_range(0, 9) == 0) ? 24'($urandom_range(
                         24'hFFFFF0, 24'hFFFFFF)) : 24'($urandom), $urandom_range(0, 12));
                6: begin
                    push_req(OP_SERASE, 24'($urandom), 25'($urandom), rnd_byte());
                    push_poll();
                end
                7: begin
                    push_req(OP_CERASE, 24'($urandom), 25'($urandom), rnd_byte());
                    push_poll();
                end
                default: push_req(3'($urandom_range(0, 7)), 24'($urandom),
                                  25'($urandom), rnd_byte());
            endcase
        end
        // lone random write-start may leave the block in write data; the final chip erase then gets an error
        push_req(OP_CERASE, 24'h0, 25'h0, 8'h00);

        while (pending_items.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_out.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        stim_done = 1;
        if (errors == 0)
            $display("spi_nor_flash_command_sequencer_core regression: pass");
        else
            $display("spi_nor_flash_command_sequencer_core regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT && !stim_done) begin
            $display("spi_nor_flash_command_sequencer_core regression: fail");
            $finish;
        end
    end
endmodule
